// File: hdl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants, codes and controller/datapath handshake types for the
// levelized topological scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

    // default sizing of the graph store
    localparam int DEF_MAX_NODES = 32;
    localparam int DEF_MAX_EDGES = 256;

    // fixed field widths of the channels
    localparam int OPCODE_W   = 2;
    localparam int NODE_IDX_W = 5;
    localparam int LEVEL_W    = 6;
    localparam int CYC_W      = 6;
    localparam int NCOUNT_W   = 6;

    // input operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_EDGE  = 2'd0,
        OP_SET_STALE = 2'd1,
        OP_RUN       = 2'd2
    } t_opcode;

    // result record kinds
    localparam logic REC_NODE   = 1'b0;
    localparam logic REC_STATUS = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic run_init;
        logic idx_zero;
        logic idx_inc;
        logic eidx_zero;
        logic eidx_inc;
        logic clr_wr;
        logic edge_rd;
        logic pend_rd_edge;
        logic err_set;
        logic cnt_wr;
        logic pend_rd_idx;
        logic scan_chk;
        logic lvl_start;
        logic ll_rd;
        logic u_load;
        logic will_chk;
        logic emit_node;
        logic dec_wr;
        logic level_inc;
        logic emit_stat;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic run_req;
        logic idx_lt_n;
        logic idx_lt_cnt;
        logic eidx_lt_total;
        logic edge_ok;
        logic rl_match;
        logic will;
        logic ncnt_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: hdl/lts_in_if.sv
// ----------------------------------------------------------------------------
// lts_in_if
// Input item channel: edge loads, stale marks and run commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface lts_in_if;
    logic                              valid;
    logic                              ready;
    logic [lts_pkg::OPCODE_W-1:0]      opcode;
    logic [lts_pkg::NODE_IDX_W-1:0]    dependent_node;
    logic [lts_pkg::NODE_IDX_W-1:0]    dependency_node;
    logic                              stale;

    modport source (output valid, opcode, dependent_node, dependency_node, stale,
                    input ready);
    modport sink   (input valid, opcode, dependent_node, dependency_node, stale,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/lts_out_if.sv
// ----------------------------------------------------------------------------
// lts_out_if
// Result channel: scheduled node records and the final status record.
// ----------------------------------------------------------------------------
`default_nettype none

interface lts_out_if;
    logic                              valid;
    logic                              ready;
    logic                              record_kind;
    logic [lts_pkg::NODE_IDX_W-1:0]    node_index;
    logic [lts_pkg::LEVEL_W-1:0]       level_number;
    logic                              rebuild;
    logic [lts_pkg::CYC_W-1:0]         cycle_count;
    logic                              load_error;
    logic                              last;

    modport source (output valid, record_kind, node_index, level_number, rebuild,
                    cycle_count, load_error, last, input ready);
    modport sink   (input valid, record_kind, node_index, level_number, rebuild,
                    cycle_count, load_error, last, output ready);
endinterface

`default_nettype wire

// File: hdl/lts_cfg_if.sv
// ----------------------------------------------------------------------------
// lts_cfg_if
// Configuration write channel for the node count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lts_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lts_pkg::NCOUNT_W-1:0]      node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

`default_nettype wire

// File: hdl/lts_datapath.sv
// ----------------------------------------------------------------------------
// lts_datapath
// Edge store, pending-count memory, level lists, flags, loop counters and the
// output record register. Acts on controller commands, reports status.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_datapath #(
    parameter int MAX_NODES = lts_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = lts_pkg::DEF_MAX_EDGES
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    lts_in_if.sink          i_in,
    lts_cfg_if.sink         i_cfg,
    lts_out_if.source       o_out,
    input  lts_pkg::t_cmd   i_cmd,
    output lts_pkg::t_status o_status
);

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int LL_AW   = $clog2(2 * MAX_NODES);
    localparam int NC_W    = lts_pkg::NCOUNT_W;

    // storage
    logic [2*NODE_W-1:0] r_edge_mem [MAX_EDGES];
    logic [ECNT_W-1:0]   r_pend_mem [MAX_NODES];
    logic [NODE_W-1:0]   r_ll_mem   [2*MAX_NODES];

    logic [2*NODE_W-1:0] r_edge_q;
    logic [ECNT_W-1:0]   r_pend_q;
    logic [NODE_W-1:0]   r_ll_q;

    // control state
    logic [NC_W-1:0]      r_node_count;
    logic [ECNT_W-1:0]    r_etotal;
    logic [MAX_NODES-1:0] r_stale;
    logic [MAX_NODES-1:0] r_build;
    logic                 r_err;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_idx;
    logic [ECNT_W-1:0]    r_eidx;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_ncnt;
    logic [CNT_W-1:0]     r_done;
    logic [CNT_W-1:0]     r_level;
    logic                 r_bank;
    logic [NODE_W-1:0]    r_u;
    logic [NODE_W-1:0]    r_w;
    logic                 r_will;
    logic                 r_out_valid;

    // output payload registers
    logic                              r_kind;
    logic [lts_pkg::NODE_IDX_W-1:0]    r_node;
    logic [lts_pkg::LEVEL_W-1:0]       r_lvl;
    logic                              r_wb;
    logic [lts_pkg::CYC_W-1:0]         r_cyc;
    logic                              r_lerr;
    logic                              r_last;

    logic [CNT_W-1:0]  w_n_lim;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_edge_wr;
    logic [NODE_W-1:0] w_edge_w;
    logic [NODE_W-1:0] w_edge_p;
    logic              w_pend_we;
    logic [NODE_W-1:0] w_pend_waddr;
    logic [ECNT_W-1:0] w_pend_wdata;
    logic              w_pend_re;
    logic [NODE_W-1:0] w_pend_raddr;
    logic              w_ll_we;
    logic [NODE_W-1:0] w_ll_wdata;
    logic [LL_AW-1:0]  w_ll_waddr;
    logic [LL_AW-1:0]  w_ll_raddr;
    logic              w_scan_push;
    logic              w_dec_push;

    // handshakes, held off during reset
    assign w_in_ready  = i_cmd.in_ready && i_rst_n;
    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = i_rst_n;
    assign w_accept    = i_in.valid && w_in_ready;

    // node count clamped to the store size
    assign w_n_lim = (r_node_count > NC_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                       : CNT_W'(r_node_count);

    // edge load check: store not full, both indices in range
    assign w_edge_wr = w_accept && (i_in.opcode == lts_pkg::OP_ADD_EDGE)
                    && (r_etotal < ECNT_W'(MAX_EDGES))
                    && (NC_W'(i_in.dependent_node) < NC_W'(w_n_lim))
                    && (NC_W'(i_in.dependency_node) < NC_W'(w_n_lim));

    assign w_edge_w = r_edge_q[2*NODE_W-1:NODE_W];
    assign w_edge_p = r_edge_q[NODE_W-1:0];

    // pending-count memory ports
    always_comb begin
        w_pend_we    = 1'b0;
        w_pend_waddr = r_w;
        w_pend_wdata = r_pend_q;
        if (i_cmd.clr_wr) begin
            w_pend_we    = 1'b1;
            w_pend_waddr = r_idx[NODE_W-1:0];
            w_pend_wdata = '0;
        end else if (i_cmd.cnt_wr) begin
            w_pend_we    = 1'b1;
            w_pend_wdata = r_pend_q + ECNT_W'(1);
        end else if (i_cmd.dec_wr && (r_pend_q != '0)) begin
            w_pend_we    = 1'b1;
            w_pend_wdata = r_pend_q - ECNT_W'(1);
        end
    end

    assign w_pend_re    = i_cmd.pend_rd_edge || i_cmd.pend_rd_idx;
    assign w_pend_raddr = i_cmd.pend_rd_edge ? w_edge_w : r_idx[NODE_W-1:0];

    // level list: next bank takes the pushes, current bank is read
    assign w_scan_push = i_cmd.scan_chk && (r_pend_q == '0);
    assign w_dec_push  = i_cmd.dec_wr && (r_pend_q == ECNT_W'(1));
    assign w_ll_we     = w_scan_push || w_dec_push;
    assign w_ll_wdata  = w_scan_push ? r_idx[NODE_W-1:0] : r_w;
    assign w_ll_waddr  = r_bank ? LL_AW'(r_ncnt) : LL_AW'(r_ncnt) + LL_AW'(MAX_NODES);
    assign w_ll_raddr  = r_bank ? LL_AW'(r_idx) + LL_AW'(MAX_NODES) : LL_AW'(r_idx);

    // memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_edge_wr) begin
            r_edge_mem[r_etotal[EDGE_AW-1:0]] <= {NODE_W'(i_in.dependent_node),
                                                  NODE_W'(i_in.dependency_node)};
        end
        if (i_cmd.edge_rd) begin
            r_edge_q <= r_edge_mem[r_eidx[EDGE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pend_we) begin
            r_pend_mem[w_pend_waddr] <= w_pend_wdata;
        end
        if (w_pend_re) begin
            r_pend_q <= r_pend_mem[w_pend_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ll_we) begin
            r_ll_mem[w_ll_waddr] <= w_ll_wdata;
        end
        if (i_cmd.ll_rd) begin
            r_ll_q <= r_ll_mem[w_ll_raddr];
        end
    end

    // configuration, load state and per-run flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_etotal     <= '0;
            r_stale      <= '0;
            r_build      <= '0;
            r_err        <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_node_count <= i_cfg.node_count;
            end
            if (w_edge_wr) begin
                r_etotal <= r_etotal + ECNT_W'(1);
            end
            if (w_accept) begin
                case (i_in.opcode)
                    lts_pkg::OP_ADD_EDGE: begin
                        if (!w_edge_wr) begin
                            r_err <= 1'b1;
                        end
                    end
                    lts_pkg::OP_SET_STALE: begin
                        if (NC_W'(i_in.dependent_node) < NC_W'(MAX_NODES)) begin
                            r_stale[NODE_W'(i_in.dependent_node)] <= i_in.stale;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.err_set) begin
                r_err <= 1'b1;
            end
            if (i_cmd.emit_node) begin
                r_build[r_u] <= r_will;
            end
            // store is emptied after the status record
            if (i_cmd.emit_stat) begin
                r_etotal <= '0;
                r_stale  <= '0;
                r_build  <= '0;
                r_err    <= 1'b0;
            end
        end
    end

    // run counters and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_eidx  <= '0;
            r_n     <= '0;
            r_cnt   <= '0;
            r_ncnt  <= '0;
            r_done  <= '0;
            r_level <= '0;
            r_bank  <= 1'b1;
        end else begin
            if (i_cmd.run_init) begin
                r_n     <= w_n_lim;
                r_ncnt  <= '0;
                r_done  <= '0;
                r_level <= '0;
                r_bank  <= 1'b1;
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.eidx_zero) begin
                r_eidx <= '0;
            end else if (i_cmd.eidx_inc) begin
                r_eidx <= r_eidx + ECNT_W'(1);
            end
            if (w_ll_we) begin
                r_ncnt <= r_ncnt + CNT_W'(1);
            end
            // next level becomes current
            if (i_cmd.lvl_start) begin
                r_cnt  <= r_ncnt;
                r_ncnt <= '0;
                r_done <= r_done + r_ncnt;
                r_bank <= ~r_bank;
            end
            if (i_cmd.level_inc) begin
                r_level <= r_level + CNT_W'(1);
            end
        end
    end

    // current node, its will-build flag and the edge target
    always_ff @(posedge i_clk) begin
        if (i_cmd.u_load) begin
            r_u    <= r_ll_q;
            r_will <= r_stale[r_ll_q];
        end else if (i_cmd.will_chk && (w_edge_w == r_u)
                     && (CNT_W'(w_edge_p) < r_n) && r_build[w_edge_p]) begin
            r_will <= 1'b1;
        end
        if (i_cmd.pend_rd_edge) begin
            r_w <= w_edge_w;
        end
    end

    // output record register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_node || i_cmd.emit_stat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_node) begin
            r_kind <= lts_pkg::REC_NODE;
            r_node <= lts_pkg::NODE_IDX_W'(r_u);
            r_lvl  <= lts_pkg::LEVEL_W'(r_level);
            r_wb   <= r_will;
            r_cyc  <= '0;
            r_lerr <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.emit_stat) begin
            r_kind <= lts_pkg::REC_STATUS;
            r_node <= '0;
            r_lvl  <= '0;
            r_wb   <= 1'b0;
            r_cyc  <= lts_pkg::CYC_W'(r_n - r_done);
            r_lerr <= r_err;
            r_last <= 1'b1;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.record_kind  = r_kind;
    assign o_out.node_index   = r_node;
    assign o_out.level_number = r_lvl;
    assign o_out.rebuild      = r_wb;
    assign o_out.cycle_count  = r_cyc;
    assign o_out.load_error   = r_lerr;
    assign o_out.last         = r_last;

    // status to controller
    assign o_status.run_req       = i_in.valid && (i_in.opcode == lts_pkg::OP_RUN);
    assign o_status.idx_lt_n      = r_idx < r_n;
    assign o_status.idx_lt_cnt    = r_idx < r_cnt;
    assign o_status.eidx_lt_total = r_eidx < r_etotal;
    assign o_status.edge_ok       = (CNT_W'(w_edge_w) < r_n) && (CNT_W'(w_edge_p) < r_n);
    assign o_status.rl_match      = (w_edge_p == r_u) && (CNT_W'(w_edge_w) < r_n);
    assign o_status.will          = r_will;
    assign o_status.ncnt_zero     = r_ncnt == '0;
    assign o_status.out_free      = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

// File: hdl/lts_controller.sv
// ----------------------------------------------------------------------------
// lts_controller
// Run sequencer: clears and counts pending dependencies, scans level 0, then
// per level computes will-build flags, emits records and releases dependents.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_controller (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  lts_pkg::t_status i_status,
    output lts_pkg::t_cmd    o_cmd
);

    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,
        S_CLR       = 19'h00002,
        S_CNT_RD    = 19'h00004,
        S_CNT_CHK   = 19'h00008,
        S_CNT_WR    = 19'h00010,
        S_SCAN_RD   = 19'h00020,
        S_SCAN_CHK  = 19'h00040,
        S_LVL_START = 19'h00080,
        S_WB_RD     = 19'h00100,
        S_WB_U      = 19'h00200,
        S_WB_ERD    = 19'h00400,
        S_WB_ECHK   = 19'h00800,
        S_WB_EMIT   = 19'h01000,
        S_RL_RD     = 19'h02000,
        S_RL_U      = 19'h04000,
        S_RL_ERD    = 19'h08000,
        S_RL_ECHK   = 19'h10000,
        S_RL_DEC    = 19'h20000,
        S_STAT      = 19'h40000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.run_req) begin
                    o_cmd.run_init = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_CLR;
                end
            end
            // zero pending counts of nodes in use
            S_CLR: begin
                if (i_status.idx_lt_n) begin
                    o_cmd.clr_wr  = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.eidx_zero = 1'b1;
                    n_state         = S_CNT_RD;
                end
            end
            // count dependencies per edge
            S_CNT_RD: begin
                if (i_status.eidx_lt_total) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_CNT_CHK;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_CNT_CHK: begin
                if (i_status.edge_ok) begin
                    o_cmd.pend_rd_edge = 1'b1;
                    n_state            = S_CNT_WR;
                end else begin
                    o_cmd.err_set  = 1'b1;
                    o_cmd.eidx_inc = 1'b1;
                    n_state        = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr   = 1'b1;
                o_cmd.eidx_inc = 1'b1;
                n_state        = S_CNT_RD;
            end
            // level 0: nodes without dependencies, in index order
            S_SCAN_RD: begin
                if (i_status.idx_lt_n) begin
                    o_cmd.pend_rd_idx = 1'b1;
                    n_state           = S_SCAN_CHK;
                end else begin
                    n_state = S_LVL_START;
                end
            end
            S_SCAN_CHK: begin
                o_cmd.scan_chk = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SCAN_RD;
            end
            S_LVL_START: begin
                if (i_status.ncnt_zero) begin
                    n_state = S_STAT;
                end else begin
                    o_cmd.lvl_start = 1'b1;
                    o_cmd.idx_zero  = 1'b1;
                    n_state         = S_WB_RD;
                end
            end
            // will-build pass over the level
            S_WB_RD: begin
                if (i_status.idx_lt_cnt) begin
                    o_cmd.ll_rd = 1'b1;
                    n_state     = S_WB_U;
                end else begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_RL_RD;
                end
            end
            S_WB_U: begin
                o_cmd.u_load    = 1'b1;
                o_cmd.eidx_zero = 1'b1;
                n_state         = S_WB_ERD;
            end
            S_WB_ERD: begin
                if (i_status.will || !i_status.eidx_lt_total) begin
                    n_state = S_WB_EMIT;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_WB_ECHK;
                end
            end
            S_WB_ECHK: begin
                o_cmd.will_chk = 1'b1;
                o_cmd.eidx_inc = 1'b1;
                n_state        = S_WB_ERD;
            end
            S_WB_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_node = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_WB_RD;
                end
            end
            // release pass: decrement dependents, push newly ready ones
            S_RL_RD: begin
                if (i_status.idx_lt_cnt) begin
                    o_cmd.ll_rd = 1'b1;
                    n_state     = S_RL_U;
                end else begin
                    o_cmd.level_inc = 1'b1;
                    n_state         = S_LVL_START;
                end
            end
            S_RL_U: begin
                o_cmd.u_load    = 1'b1;
                o_cmd.eidx_zero = 1'b1;
                n_state         = S_RL_ERD;
            end
            S_RL_ERD: begin
                if (i_status.eidx_lt_total) begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_RL_ECHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RL_RD;
                end
            end
            S_RL_ECHK: begin
                if (i_status.rl_match) begin
                    o_cmd.pend_rd_edge = 1'b1;
                    n_state            = S_RL_DEC;
                end else begin
                    o_cmd.eidx_inc = 1'b1;
                    n_state        = S_RL_ERD;
                end
            end
            S_RL_DEC: begin
                o_cmd.dec_wr   = 1'b1;
                o_cmd.eidx_inc = 1'b1;
                n_state        = S_RL_ERD;
            end
            // final status record, store cleared
            S_STAT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/levelized_topological_scheduler.sv
// Edge and stale loads: one item per cycle, no result, accepted while idle.
// Run: for every scheduled node the single-port edge store is walked once for
// the will-build flag, ending early once that flag is set, and once to release
// its dependents. Records leave through one output register; the next item is
// taken once the status record is loaded. Synchronous reset clears counts,
// flags and node count; the edge, pending and level memories are not
// cleared.
// ----------------------------------------------------------------------------
// levelized_topological_scheduler
// Level-by-level Kahn topological sort with will-build propagation.
// ----------------------------------------------------------------------------
`default_nettype none

module levelized_topological_scheduler #(
    parameter int MAX_NODES = lts_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = lts_pkg::DEF_MAX_EDGES
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lts_in_if.sink     i_in,
    lts_cfg_if.sink    i_cfg,
    lts_out_if.source  o_out
);

    lts_pkg::t_cmd    w_cmd;
    lts_pkg::t_status w_status;

    // sequencer
    lts_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // storage and arithmetic
    lts_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

`default_nettype wire

// File: sim/levelized_topological_scheduler_tb.sv
// ----------------------------------------------------------------------------
// levelized_topological_scheduler_tb
// Loads dependency graphs and stale marks into the scheduler, runs them and
// compares every node and status record with an in-bench Kahn level scheduler.
// Both channels idle and stall at random; node count changes between phases.
// ----------------------------------------------------------------------------
module levelized_topological_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES = lts_pkg::DEF_MAX_NODES;
    localparam int MAX_EDGES = lts_pkg::DEF_MAX_EDGES;
    // opcode with no operation behind it
    localparam logic [lts_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic [lts_pkg::OPCODE_W-1:0]   opcode;
        logic [lts_pkg::NODE_IDX_W-1:0] dependent_node;
        logic [lts_pkg::NODE_IDX_W-1:0] dependency_node;
        logic                           stale;
        bit                             wait_drain;
    } t_item;

    typedef struct {
        logic                           record_kind;
        logic [lts_pkg::NODE_IDX_W-1:0] node_index;
        logic [lts_pkg::LEVEL_W-1:0]    level_number;
        logic                           rebuild;
        logic [lts_pkg::CYC_W-1:0]      cycle_count;
        logic                           load_error;
        logic                           last;
    } t_record;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lts_in_if  in_bus ();
    lts_cfg_if cfg_bus ();
    lts_out_if out_bus ();

    levelized_topological_scheduler uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stimulus and expected records
    t_item            job_q [$];
    logic [lts_pkg::NCOUNT_W-1:0] cfg_q [$];
    t_record          sched_q [$];
    t_item            on_bus;
    int               mismatches = 0;
    int               hold_asked = 0;
    int               hold_served = 0;
    int               hold_left = 0;
    int               gap_left = 0;
    int               burst_left = 1;
    int               rcv_tick = 0;
    int               stall_mode = 0;
    int               clock_ticks = 0;

    // graph store of the scheduler as the bench sees it
    logic [lts_pkg::NCOUNT_W-1:0]   graph_nodes = '0;
    logic [lts_pkg::NODE_IDX_W-1:0] edge_waits [MAX_EDGES];
    logic [lts_pkg::NODE_IDX_W-1:0] edge_needs [MAX_EDGES];
    int                             edge_fill = 0;
    bit                             stale_bits [MAX_NODES];
    bit                             build_bits [MAX_NODES];
    bit                             drop_seen = 1'b0;

    function automatic int nodes_in_use();
        return (graph_nodes > MAX_NODES) ? MAX_NODES : int'(graph_nodes);
    endfunction

    function automatic void expect_rec(logic kind, int node, int lvl, bit will,
                                       int unused_nodes, bit err, bit last);
        t_record r;
        r.record_kind  = kind;
        r.node_index   = node[lts_pkg::NODE_IDX_W-1:0];
        r.level_number = lvl[lts_pkg::LEVEL_W-1:0];
        r.rebuild      = will;
        r.cycle_count  = unused_nodes[lts_pkg::CYC_W-1:0];
        r.load_error   = err;
        r.last         = last;
        sched_q.push_back(r);
    endfunction

    // one Kahn pass, level by level, then the store is cleared
    function automatic void schedule_graph();
        int n;
        int pend [MAX_NODES];
        int cur [$];
        int nxt [$];
        int lvl;
        int done;
        int u;
        int w;
        bit err;
        bit will;
        n    = nodes_in_use();
        err  = drop_seen;
        lvl  = 0;
        done = 0;
        foreach (pend[i]) pend[i] = 0;
        for (int e = 0; e < edge_fill; e++) begin
            if (edge_waits[e] < n && edge_needs[e] < n) pend[edge_waits[e]]++;
            else err = 1'b1;
        end
        for (int i = 0; i < n; i++)
            if (pend[i] == 0) cur.push_back(i);
        while (cur.size() > 0) begin
            // will-build: own stale mark or any building dependency
            foreach (cur[i]) begin
                u = cur[i];
                will = stale_bits[u];
                for (int e = 0; e < edge_fill && !will; e++)
                    if (edge_waits[e] == u && edge_needs[e] < n && build_bits[edge_needs[e]])
                        will = 1'b1;
                build_bits[u] = will;
                expect_rec(lts_pkg::REC_NODE, u, lvl, will, 0, 1'b0, 1'b0);
            end
            done += cur.size();
            // release dependents in edge-arrival order
            nxt.delete();
            foreach (cur[i]) begin
                for (int e = 0; e < edge_fill; e++) begin
                    w = edge_waits[e];
                    if (edge_needs[e] == cur[i] && w < n && pend[w] > 0) begin
                        pend[w]--;
                        if (pend[w] == 0 && nxt.size() < MAX_NODES) nxt.push_back(w);
                    end
                end
            end
            cur = nxt;
            lvl++;
        end
        expect_rec(lts_pkg::REC_STATUS, 0, 0, 1'b0, n - done, err, 1'b1);
        edge_fill = 0;
        drop_seen = 1'b0;
        foreach (stale_bits[i]) begin
            stale_bits[i] = 1'b0;
            build_bits[i] = 1'b0;
        end
    endfunction

    function automatic void apply_item(t_item it);
        int n;
        n = nodes_in_use();
        case (it.opcode)
            lts_pkg::OP_ADD_EDGE: begin
                if (edge_fill >= MAX_EDGES || it.dependent_node >= n
                        || it.dependency_node >= n) begin
                    drop_seen = 1'b1;
                end else begin
                    edge_waits[edge_fill] = it.dependent_node;
                    edge_needs[edge_fill] = it.dependency_node;
                    edge_fill++;
                end
            end
            lts_pkg::OP_SET_STALE: begin
                if (it.dependent_node < MAX_NODES) stale_bits[it.dependent_node] = it.stale;
            end
            lts_pkg::OP_RUN: schedule_graph();
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver: bursts with random gaps, fed from job_q
    always @(posedge i_clk) begin : feed
        t_item pick;
        bit    offer;
        if (!i_rst_n) begin
            in_bus.valid           <= 1'b0;
            in_bus.opcode          <= '0;
            in_bus.dependent_node  <= '0;
            in_bus.dependency_node <= '0;
            in_bus.stale           <= 1'b0;
            edge_fill  = 0;
            drop_seen  = 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (in_bus.valid && in_bus.ready) apply_item(on_bus);
            if (!in_bus.valid || in_bus.ready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (job_q.size() > 0
                        && !(job_q[0].wait_drain && sched_q.size() > 0)) begin
                    pick   = job_q.pop_front();
                    offer  = 1'b1;
                    on_bus = pick;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                in_bus.valid <= offer;
                if (offer) begin
                    in_bus.opcode          <= pick.opcode;
                    in_bus.dependent_node  <= pick.dependent_node;
                    in_bus.dependency_node <= pick.dependency_node;
                    in_bus.stale           <= pick.stale;
                end
            end
        end
    end

    // node count writes, only issued while the block is idle
    always @(posedge i_clk) begin : cfg_feed
        if (!i_rst_n) begin
            cfg_bus.valid      <= 1'b0;
            cfg_bus.node_count <= '0;
            graph_nodes = '0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) graph_nodes = cfg_bus.node_count;
            if (!cfg_bus.valid || cfg_bus.ready) begin
                if (cfg_q.size() > 0) begin
                    cfg_bus.valid      <= 1'b1;
                    cfg_bus.node_count <= cfg_q.pop_front();
                end else begin
                    cfg_bus.valid <= 1'b0;
                end
            end
        end
    end

    // record checker and receiver stall pattern
    always @(posedge i_clk) begin : collect
        t_record want;
        logic    rdy;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (sched_q.size() == 0) begin
                    $error("record with no expectation: kind %0d node %0d",
                           out_bus.record_kind, out_bus.node_index);
                    mismatches++;
                end else begin
                    want = sched_q.pop_front();
                    check_field("record_kind", want.record_kind, out_bus.record_kind);
                    check_field("node_index", want.node_index, out_bus.node_index);
                    check_field("level_number", want.level_number, out_bus.level_number);
                    check_field("rebuild", want.rebuild, out_bus.rebuild);
                    check_field("cycle_count", want.cycle_count, out_bus.cycle_count);
                    check_field("load_error", want.load_error, out_bus.load_error);
                    check_field("last", want.last, out_bus.last);
                end
            end
            if (hold_served != hold_asked) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            rcv_tick++;
            if (rcv_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = (rcv_tick % 4 == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            out_bus.ready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        clock_ticks++;
        if (clock_ticks >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_item(logic [lts_pkg::OPCODE_W-1:0] op, int a, int b, bit st,
                              bit drain = 1'b0);
        t_item it;
        it.opcode          = op;
        it.dependent_node  = a[lts_pkg::NODE_IDX_W-1:0];
        it.dependency_node = b[lts_pkg::NODE_IDX_W-1:0];
        it.stale           = st;
        it.wait_drain      = drain;
        job_q.push_back(it);
    endtask

    // wait until all items are taken and every record has come back
    task automatic settle();
        do @(negedge i_clk);
        while (job_q.size() > 0 || in_bus.valid || sched_q.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_nodes(int n);
        cfg_q.push_back(n[lts_pkg::NCOUNT_W-1:0]);
        do @(negedge i_clk);
        while (cfg_q.size() > 0 || cfg_bus.valid);
    endtask

    // random item with mostly acyclic edges over the nodes in use
    task automatic queue_random(int n, output bit counted);
        int nn;
        int r;
        int a;
        nn = (n > MAX_NODES) ? MAX_NODES : n;
        r  = $urandom_range(0, 19);
        counted = 1'b1;
        if (r < 11 && nn >= 2) begin
            a = $urandom_range(1, nn - 1);
            queue_item(lts_pkg::OP_ADD_EDGE, a, $urandom_range(0, a - 1),
                       $urandom_range(0, 1));
        end else if (r < 15) begin
            a = (nn > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, nn - 1)
                                                      : $urandom_range(0, 31);
            queue_item(lts_pkg::OP_SET_STALE, a, $urandom_range(0, 31), $urandom_range(0, 1));
        end else if (r < 18) begin
            queue_item(lts_pkg::OP_ADD_EDGE, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1));
        end else if (r == 18) begin
            queue_item(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1));
            counted = 1'b0;
        end else begin
            queue_item(lts_pkg::OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1), $urandom_range(0, 1));
        end
    endtask

    initial begin : stimulus
        int  made;
        int  n;
        int  loads;
        bit  counted;
        in_bus.valid           = 1'b0;
        in_bus.opcode          = '0;
        in_bus.dependent_node  = '0;
        in_bus.dependency_node = '0;
        in_bus.stale           = 1'b0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.node_count     = '0;
        out_bus.ready          = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty graph: bad-index edge, unused opcode, status-only run
        set_nodes(0);
        queue_item(lts_pkg::OP_ADD_EDGE, 0, 0, 1'b0);
        queue_item(OP_UNUSED, 31, 31, 1'b1);
        queue_item(lts_pkg::OP_RUN, 0, 0, 1'b0);
        settle();

        // full node range: duplicates, self loop, two-node cycle, stale chain
        set_nodes(32);
        queue_item(lts_pkg::OP_SET_STALE, 31, 0, 1'b1);
        queue_item(lts_pkg::OP_SET_STALE, 2, 0, 1'b1);
        queue_item(lts_pkg::OP_SET_STALE, 2, 0, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 31, 0, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 1, 0, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 1, 0, 1'b1);
        queue_item(lts_pkg::OP_ADD_EDGE, 2, 1, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 5, 31, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 3, 3, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 4, 6, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 6, 4, 1'b0);
        queue_item(lts_pkg::OP_RUN, 31, 31, 1'b1);
        settle();

        // node count above the store size is clamped
        set_nodes(63);
        queue_item(lts_pkg::OP_ADD_EDGE, 31, 30, 1'b0);
        queue_item(lts_pkg::OP_SET_STALE, 30, 0, 1'b1);
        queue_item(lts_pkg::OP_RUN, 0, 0, 1'b0);
        settle();

        // edge out of range at load, then one that no longer fits at run time
        set_nodes(8);
        queue_item(lts_pkg::OP_ADD_EDGE, 7, 3, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 2, 20, 1'b0);
        queue_item(lts_pkg::OP_ADD_EDGE, 3, 0, 1'b0);
        settle();
        set_nodes(4);
        queue_item(lts_pkg::OP_RUN, 0, 0, 1'b0);
        settle();

        // receiver holds off while loads pile up behind a run
        set_nodes(12);
        for (int i = 1; i < 12; i++) queue_item(lts_pkg::OP_ADD_EDGE, i, i - 1, 1'b0);
        queue_item(lts_pkg::OP_SET_STALE, 0, 0, 1'b1);
        queue_item(lts_pkg::OP_RUN, 0, 0, 1'b0);
        hold_asked++;
        for (int i = 0; i < 6; i++) queue_item(lts_pkg::OP_ADD_EDGE, i + 4, i, 1'b0);
        queue_item(lts_pkg::OP_RUN, 0, 0, 1'b0, 1'b1);
        settle();

        // random phases, each at its own node count, each closed by a run
        made = 0;
        while (made < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: n = 0;
                1: n = 32;
                2: n = $urandom_range(33, 63);
                3: n = 1;
                default: n = $urandom_range(2, 12);
            endcase
            set_nodes(n);
            loads = $urandom_range(2, 14);
            for (int i = 0; i < loads; i++) begin
                queue_random(n, counted);
                if (counted) made++;
            end
            queue_item(lts_pkg::OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1));
            made++;
            settle();
        end

        do @(negedge i_clk);
        while (job_q.size() > 0 || in_bus.valid || sched_q.size() > 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: levelized_topological_scheduler.f
hdl/lts_pkg.sv
hdl/lts_in_if.sv
hdl/lts_out_if.sv
hdl/lts_cfg_if.sv
hdl/lts_datapath.sv
hdl/lts_controller.sv
hdl/levelized_topological_scheduler.sv
sim/levelized_topological_scheduler_tb.sv
